// ----- sv/cpnt_pkg.sv -----
// Shared types, constants and field widths for the channel pedestal/noise tracker.
package cpnt_pkg;

	localparam int BoardW    = 5;
	localparam int LinkW     = 5;
	localparam int FrontendW = 6;
	localparam int ChannelW  = 6;
	localparam int SampleW   = 10;
	localparam int MeanW     = 18;
	localparam int CountW    = 32;
	localparam int DevW      = 56;
	localparam int RmsW      = 18;
	localparam int DiffW     = 19;   // signed S - p

	localparam int BOARD_COUNT_DEF           = 2;
	localparam int LINKS_PER_BOARD_DEF       = 24;
	localparam int FRONTENDS_PER_LINK_DEF    = 40;
	localparam int CHANNELS_PER_FRONTEND_DEF = 64;

	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
	localparam logic [DevW-1:0]   DevMax   = {DevW{1'b1}};
	localparam logic [RmsW-1:0]   RmsMax   = {RmsW{1'b1}};

	// one table entry
	typedef struct packed {
		logic [CountW-1:0] count;
		logic [MeanW-1:0]  mean;
		logic [DevW-1:0]   dev;
	} entry_t;

	// request to the divide unit and its answer
	typedef struct packed {
		logic              start;
		logic              sqrt_mode;
		logic [DevW-1:0]   num;
		logic [CountW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [DevW-1:0] result;
	} div_rsp_t;

endpackage

// ----- sv/cpnt_divsqrt.sv -----
// Shared iterative unit: restoring divide (one quotient bit a cycle) or square root (one bit a cycle).
module cpnt_divsqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  cpnt_pkg::div_req_t req,
	output cpnt_pkg::div_rsp_t rsp
);
	import cpnt_pkg::*;

	localparam int StepW = $clog2(DevW + 1);

	logic              busy_q;
	logic              mode_q;
	logic [StepW-1:0]  step_q;
	logic [DevW-1:0]   num_q;     // shifts out numerator bits (divide) / value (sqrt)
	logic [CountW-1:0] den_q;
	logic [DevW:0]     rem_q;     // partial remainder
	logic [DevW-1:0]   quo_q;
	logic              done_q;

	// divide step
	logic [DevW:0]   rem_sh;
	logic [DevW:0]   rem_sub;
	logic            rem_ge;
	// sqrt step: two value bits enter per cycle
	logic [DevW+1:0] srem_sh;
	logic [DevW+1:0] strial;
	logic            s_ge;

	always_comb begin
		rem_sh  = {rem_q[DevW-1:0], num_q[DevW-1]};
		rem_ge  = rem_sh >= {{(DevW+1-CountW){1'b0}}, den_q};
		rem_sub = rem_sh - {{(DevW+1-CountW){1'b0}}, den_q};
		srem_sh = {rem_q[DevW-1:0], num_q[DevW-1:DevW-2]};
		strial  = {quo_q, 2'b01};
		s_ge    = srem_sh >= strial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				mode_q <= req.sqrt_mode;
				num_q  <= req.num;
				den_q  <= req.den;
				rem_q  <= '0;
				quo_q  <= '0;
				step_q <= req.sqrt_mode ? StepW'(DevW/2) : StepW'(DevW);
			end else if (busy_q) begin
				if (!mode_q) begin
					num_q <= {num_q[DevW-2:0], 1'b0};
					rem_q <= rem_ge ? rem_sub : rem_sh;
					quo_q <= {quo_q[DevW-2:0], rem_ge};
				end else begin
					num_q <= {num_q[DevW-3:0], 2'b00};
					rem_q <= s_ge ? (DevW+1)'(srem_sh - strial) : srem_sh[DevW:0];
					quo_q <= {quo_q[DevW-2:0], s_ge};
				end
				step_q <= step_q - 1'b1;
				if (step_q == StepW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = quo_q;

	property p_done_ends_busy;
		@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q;
	endproperty
	a_done_ends_busy: assert property (p_done_ends_busy) else $error("done while busy");

	property p_no_start_busy;
		@(posedge clk) disable iff (!arst_n) busy_q |-> !req.start;
	endproperty
	a_no_start_busy: assert property (p_no_start_busy) else $error("start while busy");

	property p_step_nonzero;
		@(posedge clk) disable iff (!arst_n) busy_q |-> step_q != '0;
	endproperty
	a_step_nonzero: assert property (p_step_nonzero) else $error("busy with zero steps");

endmodule

// ----- sv/cpnt_table.sv -----
// Channel state memory with a registered read and a clearing sweep after reset.
module cpnt_table #(
	parameter int Depth = 4,
	parameter int AddrW = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [AddrW-1:0]     rd_addr,
	output cpnt_pkg::entry_t     rd_data,
	input  logic                 wr_en,
	input  logic [AddrW-1:0]     wr_addr,
	input  cpnt_pkg::entry_t     wr_data,
	output logic                 clearing
);
	import cpnt_pkg::*;

	entry_t           mem [Depth];
	logic [AddrW:0]   clr_q;
	logic             clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == (AddrW+1)'(Depth - 1)) clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) mem[clr_q[AddrW-1:0]] <= '0;
		else if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data <= mem[rd_addr];
	end

	assign clearing = clr_busy_q;

	property p_no_write_clearing;
		@(posedge clk) disable iff (!arst_n) clr_busy_q |-> !wr_en && !rd_en;
	endproperty
	a_no_write_clearing: assert property (p_no_write_clearing) else $error("access during clear");

	property p_clear_in_range;
		@(posedge clk) disable iff (!arst_n) clr_busy_q |-> clr_q < (AddrW+1)'(Depth);
	endproperty
	a_clear_in_range: assert property (p_clear_in_range) else $error("clear out of range");

	property p_clear_once;
		@(posedge clk) disable iff (!arst_n) !clr_busy_q |=> !clr_busy_q;
	endproperty
	a_clear_once: assert property (p_clear_once) else $error("clear restarted");

endmodule

// ----- sv/channel_pedestal_noise_tracker.sv -----
// Top level: per-channel Welford pedestal and noise tracker.
//
//  channel  direction  handshake               payload
//  in       sink       in_valid / in_stall     board_index .. last_sample
//  out      source     out_valid / out_stall   out_board .. count_seen
//
// One item at a time. An accepted item takes a memory read, a mean divide
// and its wait, then multiply/accumulate and write-back; a last item adds a
// divide of M by N and a square root, each with its start and wait states,
// all on the shared divide/sqrt unit. Dropped items are accepted in the
// idle state without leaving it.
// After reset the table is swept clear, one entry a cycle, over every entry
// of the table (122880 by default), with in_stall high.
// The result waits in an output register; while out_stall holds it, a new
// item is still taken and worked up to the point where it needs that register.
module channel_pedestal_noise_tracker #(
	parameter int BOARD_COUNT           = cpnt_pkg::BOARD_COUNT_DEF,
	parameter int LINKS_PER_BOARD       = cpnt_pkg::LINKS_PER_BOARD_DEF,
	parameter int FRONTENDS_PER_LINK    = cpnt_pkg::FRONTENDS_PER_LINK_DEF,
	parameter int CHANNELS_PER_FRONTEND = cpnt_pkg::CHANNELS_PER_FRONTEND_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [cpnt_pkg::BoardW-1:0]    board_index,
	input  logic [cpnt_pkg::LinkW-1:0]     link_index,
	input  logic [cpnt_pkg::FrontendW-1:0] frontend_addr,
	input  logic [cpnt_pkg::ChannelW-1:0]  channel_addr,
	input  logic [cpnt_pkg::SampleW-1:0]   sample_value,
	input  logic                           last_sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [cpnt_pkg::BoardW-1:0]    out_board,
	output logic [cpnt_pkg::LinkW-1:0]     out_link,
	output logic [cpnt_pkg::FrontendW-1:0] out_frontend,
	output logic [cpnt_pkg::ChannelW-1:0]  out_channel,
	output logic [cpnt_pkg::MeanW-1:0]     mean_level,
	output logic [cpnt_pkg::RmsW-1:0]      rms_noise,
	output logic [cpnt_pkg::CountW-1:0]    count_seen
);
	import cpnt_pkg::*;

	localparam int Depth = BOARD_COUNT * LINKS_PER_BOARD * FRONTENDS_PER_LINK
		* CHANNELS_PER_FRONTEND;
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

	localparam logic [3:0] StIdle  = 4'd0;
	localparam logic [3:0] StRead  = 4'd1;
	localparam logic [3:0] StDivM  = 4'd2;
	localparam logic [3:0] StWaitM = 4'd3;
	localparam logic [3:0] StMul   = 4'd4;
	localparam logic [3:0] StAcc   = 4'd5;
	localparam logic [3:0] StDivV  = 4'd6;
	localparam logic [3:0] StWaitV = 4'd7;
	localparam logic [3:0] StSqrt  = 4'd8;
	localparam logic [3:0] StWaitS = 4'd9;
	localparam logic [3:0] StEmit  = 4'd10;

	logic [3:0]           state_q;
	logic [BoardW-1:0]    board_q;
	logic [LinkW-1:0]     link_q;
	logic [FrontendW-1:0] fe_q;
	logic [ChannelW-1:0]  ch_q;
	logic [SampleW-1:0]   sample_q;
	logic                 last_q;
	logic [AddrW-1:0]     addr_q;
	logic [CountW-1:0]    n_q;
	logic [MeanW-1:0]     p0_q;
	logic [MeanW-1:0]     p_q;
	logic [DevW-1:0]      m0_q;
	logic [DevW-1:0]      m_q;
	logic [2*DiffW-1:0]   prod_q;
	logic                 neg_q;

	entry_t   rd_data;
	entry_t   wr_data;
	logic     wr_en;
	logic     clearing;
	div_req_t dreq;
	div_rsp_t drsp;

	logic       addr_ok;
	logic [AddrW-1:0] addr_in;
	logic       accept;

	always_comb begin
		addr_ok = (32'(board_index) < 32'(BOARD_COUNT))
			&& (32'(link_index) < 32'(LINKS_PER_BOARD))
			&& (32'(frontend_addr) < 32'(FRONTENDS_PER_LINK))
			&& (32'(channel_addr) < 32'(CHANNELS_PER_FRONTEND));
		addr_in = AddrW'((((32'(board_index) * 32'(LINKS_PER_BOARD) + 32'(link_index))
			* 32'(FRONTENDS_PER_LINK) + 32'(frontend_addr)) * 32'(CHANNELS_PER_FRONTEND))
			+ 32'(channel_addr));
	end

	assign in_stall = clearing || (state_q != StIdle);
	assign accept   = in_valid && !in_stall;

	// |S - p0| and its sign
	logic [MeanW-1:0] s_fx;
	logic [DiffW-1:0] d0;
	logic [MeanW-1:0] d0_abs;
	logic [MeanW-1:0] d1_abs;
	logic [MeanW-1:0] q_w;
	logic [DevW:0]    m_sum;

	always_comb begin
		s_fx   = {sample_q, 8'd0};
		d0     = {1'b0, s_fx} - {1'b0, p0_q};
		d0_abs = d0[DiffW-1] ? MeanW'(-d0) : d0[MeanW-1:0];
		q_w    = drsp.result[MeanW-1:0];
		// p moves toward S by q, so |S - p| = |d0| - q
		d1_abs = MeanW'(d0_abs - q_w);
		m_sum  = {1'b0, m0_q} + {{(DevW+1-2*DiffW){1'b0}}, prod_q};
	end

	cpnt_table #(.Depth(Depth), .AddrW(AddrW)) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept && addr_ok),
		.rd_addr  (addr_in),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (addr_q),
		.wr_data  (wr_data),
		.clearing (clearing)
	);

	cpnt_divsqrt u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_comb begin
		dreq = '0;
		wr_en = (state_q == StAcc);
		wr_data.count = n_q;
		wr_data.mean  = p_q;
		wr_data.dev   = m_sum[DevW] ? DevMax : m_sum[DevW-1:0];
		case (state_q)
			StDivM: begin
				dreq.start = 1'b1;
				dreq.num   = {{(DevW-MeanW){1'b0}}, d0_abs};
				dreq.den   = n_q;
			end
			StDivV: begin
				dreq.start = 1'b1;
				dreq.num   = m_q;
				dreq.den   = n_q;
			end
			StSqrt: begin
				dreq.start     = 1'b1;
				dreq.sqrt_mode = 1'b1;
				dreq.num       = m_q;
			end
			default: dreq = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= StIdle;
			out_valid <= 1'b0;
		end else begin
			// drop the taken result unless a new one replaces it this cycle
			if (out_valid && !out_stall && state_q != StEmit) out_valid <= 1'b0;
			case (state_q)
				StIdle: begin
					if (accept && addr_ok) begin
						board_q  <= board_index;
						link_q   <= link_index;
						fe_q     <= frontend_addr;
						ch_q     <= channel_addr;
						sample_q <= sample_value;
						last_q   <= last_sample;
						addr_q   <= addr_in;
						state_q  <= StRead;
					end
				end
				StRead: begin
					n_q     <= (rd_data.count == CountMax) ? CountMax : rd_data.count + 1'b1;
					p0_q    <= rd_data.mean;
					m0_q    <= rd_data.dev;
					state_q <= StDivM;
				end
				StDivM: state_q <= StWaitM;
				StWaitM: begin
					if (drsp.done) begin
						p_q     <= d0[DiffW-1] ? MeanW'(p0_q - q_w) : MeanW'(p0_q + q_w);
						neg_q   <= d0[DiffW-1];
						state_q <= StMul;
					end
				end
				StMul: begin
					// d0 and d1 share a sign, so the product is |d0|*|d1|
					prod_q  <= (2*DiffW)'(d0_abs) * (2*DiffW)'(d1_abs);
					state_q <= StAcc;
				end
				StAcc: begin
					m_q     <= wr_data.dev;
					state_q <= last_q ? StDivV : StIdle;
				end
				StDivV: state_q <= StWaitV;
				StWaitV: begin
					if (drsp.done) begin
						m_q     <= drsp.result;
						state_q <= StSqrt;
					end
				end
				StSqrt: state_q <= StWaitS;
				StWaitS: if (drsp.done) state_q <= StEmit;
				StEmit: begin
					if (!out_valid || !out_stall) begin
						out_valid    <= 1'b1;
						out_board    <= board_q;
						out_link     <= link_q;
						out_frontend <= fe_q;
						out_channel  <= ch_q;
						mean_level   <= p_q;
						rms_noise    <= (drsp.result > DevW'(RmsMax)) ? RmsMax
							: drsp.result[RmsW-1:0];
						count_seen   <= n_q;
						state_q      <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	// keep rms_noise valid across the emit wait: result register holds until next start
	property p_emit_only_last;
		@(posedge clk) disable iff (!arst_n) (state_q == StEmit) |-> last_q;
	endproperty
	a_emit_only_last: assert property (p_emit_only_last) else $error("emit without last");

	property p_write_count_nonzero;
		@(posedge clk) disable iff (!arst_n) wr_en |-> n_q != '0;
	endproperty
	a_write_count_nonzero: assert property (p_write_count_nonzero) else $error("zero count");

	property p_no_accept_busy;
		@(posedge clk) disable iff (!arst_n) (state_q != StIdle) |-> !accept;
	endproperty
	a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

	property p_mean_between;
		@(posedge clk) disable iff (!arst_n) (state_q == StMul) |->
			(neg_q ? (p_q <= p0_q && p_q >= s_fx) : (p_q >= p0_q && p_q <= s_fx));
	endproperty
	a_mean_between: assert property (p_mean_between) else $error("mean out of range");

endmodule

// ----- test/channel_pedestal_noise_tracker_tb.sv -----
// Testbench for channel_pedestal_noise_tracker: random hits against a per-channel Welford predictor.
module channel_pedestal_noise_tracker_tb;
	import cpnt_pkg::*;

	localparam int NumBoards    = BOARD_COUNT_DEF;
	localparam int NumLinks     = LINKS_PER_BOARD_DEF;
	localparam int NumFrontends = FRONTENDS_PER_LINK_DEF;
	localparam int NumChannels  = CHANNELS_PER_FRONTEND_DEF;
	localparam int RandomItems  = 1150;
	localparam int QuietTail    = 150;
	localparam longint CycleLimit = 3000000;

	typedef struct {
		logic [BoardW-1:0]    board;
		logic [LinkW-1:0]     link;
		logic [FrontendW-1:0] fe;
		logic [ChannelW-1:0]  ch;
		logic [SampleW-1:0]   adc;
		logic                 last;
		bit                   drain;
	} adc_item_t;

	typedef struct {
		logic [BoardW-1:0]    board;
		logic [LinkW-1:0]     link;
		logic [FrontendW-1:0] fe;
		logic [ChannelW-1:0]  ch;
		logic [MeanW-1:0]     mean;
		logic [RmsW-1:0]      rms;
		logic [CountW-1:0]    count;
	} noise_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [BoardW-1:0] board_index = '0;
	logic [LinkW-1:0] link_index = '0;
	logic [FrontendW-1:0] frontend_addr = '0;
	logic [ChannelW-1:0] channel_addr = '0;
	logic [SampleW-1:0] sample_value = '0;
	logic last_sample = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [BoardW-1:0] out_board;
	logic [LinkW-1:0] out_link;
	logic [FrontendW-1:0] out_frontend;
	logic [ChannelW-1:0] out_channel;
	logic [MeanW-1:0] mean_level;
	logic [RmsW-1:0] rms_noise;
	logic [CountW-1:0] count_seen;

	// per-channel state, absent entries read as zero
	logic [CountW-1:0] chan_count [int];
	logic [MeanW-1:0]  chan_mean [int];
	logic [DevW-1:0]   chan_dev [int];

	adc_item_t     sample_queue[$];
	noise_report_t pending_reports[$];
	adc_item_t     cur_item;
	int            tx_gap, rx_gap;
	int            errors, items_taken, items_dropped, reports_seen;
	longint        cycles;

	channel_pedestal_noise_tracker dut (.*);

	always #2 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Welford update of one channel, or count an out-of-range item as dropped; queue a report on the last sample of a hit
	task automatic track_sample(adc_item_t it);
		int idx;
		logic [CountW-1:0] n;
		longint s, p0, p, d0, d1;
		longint unsigned prod, m, rms;
		noise_report_t rep;
		if (it.board >= NumBoards || it.link >= NumLinks || it.fe >= NumFrontends
				|| it.ch >= NumChannels) begin
			items_dropped++;
			return;
		end
		idx = ((int'(it.board) * NumLinks + it.link) * NumFrontends + it.fe) * NumChannels
			+ it.ch;
		n = chan_count.exists(idx) ? chan_count[idx] : '0;
		if (n != CountMax) n++;
		chan_count[idx] = n;
		s = longint'(it.adc) << 8;
		p0 = chan_mean.exists(idx) ? longint'(chan_mean[idx]) : 0;
		d0 = s - p0;
		p = p0 + d0 / longint'({32'd0, n});
		chan_mean[idx] = p[MeanW-1:0];
		d1 = s - p;
		prod = longint'(d0 * d1);
		m = chan_dev.exists(idx) ? {8'd0, chan_dev[idx]} : 0;
		if (prod > {8'd0, DevMax} - m) m = {8'd0, DevMax};
		else m += prod;
		chan_dev[idx] = m[DevW-1:0];
		if (!it.last) return;
		rms = int_sqrt(m / {32'd0, n});
		if (rms > RmsMax) rms = RmsMax;
		rep.board = it.board;
		rep.link  = it.link;
		rep.fe    = it.fe;
		rep.ch    = it.ch;
		rep.mean  = p[MeanW-1:0];
		rep.rms   = rms[RmsW-1:0];
		rep.count = n;
		pending_reports.insert(pending_reports.size(), rep);
	endtask

	task automatic add_sample(int b, int l, int f, int c, int a, bit last, bit drain = 0);
		adc_item_t it;
		it.board = BoardW'(b);
		it.link  = LinkW'(l);
		it.fe    = FrontendW'(f);
		it.ch    = ChannelW'(c);
		it.adc   = SampleW'(a);
		it.last  = last;
		it.drain = drain;
		sample_queue.insert(sample_queue.size(), it);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				track_sample(cur_item);
				items_taken++;
			end
			if (!(in_valid && in_stall)) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (sample_queue.size() > 0
						&& !(sample_queue[0].drain && pending_reports.size() > 0)) begin
					cur_item = sample_queue.pop_front();
					board_index   <= cur_item.board;
					link_index    <= cur_item.link;
					frontend_addr <= cur_item.fe;
					channel_addr  <= cur_item.ch;
					sample_value  <= cur_item.adc;
					last_sample   <= cur_item.last;
					in_valid      <= 1'b1;
					if (sample_queue.size() > QuietTail && $urandom_range(0, 3) == 0)
						tx_gap = $urandom_range(1, 7);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				reports_seen++;
				if (pending_reports.size() == 0) begin
					$error("unexpected report for board %0d link %0d fe %0d ch %0d",
						out_board, out_link, out_frontend, out_channel);
					errors++;
				end else begin
					noise_report_t e;
					e = pending_reports.pop_front();
					if (out_board !== e.board) begin
						$error("out_board exp %0d got %0d", e.board, out_board); errors++;
					end
					if (out_link !== e.link) begin
						$error("out_link exp %0d got %0d", e.link, out_link); errors++;
					end
					if (out_frontend !== e.fe) begin
						$error("out_frontend exp %0d got %0d", e.fe, out_frontend); errors++;
					end
					if (out_channel !== e.ch) begin
						$error("out_channel exp %0d got %0d", e.ch, out_channel); errors++;
					end
					if (mean_level !== e.mean) begin
						$error("mean_level exp %0d got %0d", e.mean, mean_level); errors++;
					end
					if (rms_noise !== e.rms) begin
						$error("rms_noise exp %0d got %0d", e.rms, rms_noise); errors++;
					end
					if (count_seen !== e.count) begin
						$error("count_seen exp %0d got %0d", e.count, count_seen); errors++;
					end
				end
			end
			if (rx_gap > 0) begin
				rx_gap--;
				out_stall <= 1'b1;
			end else if (sample_queue.size() > QuietTail && $urandom_range(0, 4) == 0) begin
				rx_gap = $urandom_range(0, 6);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d reports outstanding", cycles,
				pending_reports.size());
			$display("FAIL channel_pedestal_noise_tracker");
			$finish;
		end
	end

	initial begin
		int hot_b[12], hot_l[12], hot_f[12], hot_c[12];
		int b, l, f, c, len, base, spread, hits;
		errors = 0;
		items_taken = 0;
		items_dropped = 0;
		reports_seen = 0;
		cycles = 0;

		// address extremes, sample extremes, drops even with last set
		add_sample(0, 0, 0, 0, 0, 1);
		add_sample(1, 23, 39, 63, 1023, 1);
		add_sample(1, 23, 39, 63, 0, 0);
		add_sample(1, 23, 39, 63, 1023, 0);
		add_sample(1, 23, 39, 63, 0, 1);
		add_sample(31, 31, 63, 63, 1023, 1);
		add_sample(2, 0, 0, 0, 500, 1);
		add_sample(0, 24, 0, 0, 500, 1);
		add_sample(0, 0, 40, 0, 500, 1);
		add_sample(0, 0, 0, 0, 1023, 0);
		add_sample(0, 0, 0, 0, 1023, 0);
		add_sample(0, 0, 0, 0, 1, 1);
		for (int i = 0; i < 6; i++) add_sample(0, 5, 7, 33, (i % 2) ? 1023 : 0, i == 5);
		add_sample(1, 0, 20, 1, 512, 1, 1);

		for (int i = 0; i < 12; i++) begin
			hot_b[i] = $urandom_range(0, NumBoards - 1);
			hot_l[i] = $urandom_range(0, NumLinks - 1);
			hot_f[i] = $urandom_range(0, NumFrontends - 1);
			hot_c[i] = $urandom_range(0, NumChannels - 1);
		end
		hits = 0;
		while (sample_queue.size() < RandomItems) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise: unconstrained fields, mostly out of range
				add_sample($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 1023), $urandom_range(0, 1) == 1);
				continue;
			end
			if ($urandom_range(0, 9) < 7) begin
				int k;
				k = $urandom_range(0, 11);
				b = hot_b[k]; l = hot_l[k]; f = hot_f[k]; c = hot_c[k];
			end else begin
				b = $urandom_range(0, NumBoards - 1);
				l = $urandom_range(0, NumLinks - 1);
				f = $urandom_range(0, NumFrontends - 1);
				c = $urandom_range(0, NumChannels - 1);
			end
			len = $urandom_range(1, 8);
			base = $urandom_range(0, 1023);
			spread = $urandom_range(0, 3) == 0 ? 1023 : $urandom_range(0, 20);
			hits++;
			for (int j = 0; j < len; j++) begin
				int a;
				a = base + $urandom_range(0, 2 * spread) - spread;
				if (a < 0) a = 0;
				if (a > 1023) a = 1023;
				add_sample(b, l, f, c, a, j == len - 1, j == 0 && hits % 60 == 0);
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (sample_queue.size() != 0 || in_valid) @(posedge clk);
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("%0d samples taken (%0d dropped), %0d hit reports checked, %0d hits generated",
			items_taken, items_dropped, reports_seen, hits);
		$display("%0d channels touched, %0d mismatches", chan_count.num(), errors);
		if (errors == 0 && pending_reports.size() == 0)
			$display("PASS channel_pedestal_noise_tracker");
		else
			$display("FAIL channel_pedestal_noise_tracker");
		$finish;
	end

endmodule
